// ===== rtl/mvnq_pkg.sv =====
// Shared types, codes and fixed-point helpers for the log density core.
`default_nettype none

package mvnq_pkg;

   // Action codes of an input transaction
   localparam logic [1:0] ACT_START  = 2'd0;
   localparam logic [1:0] ACT_VECTOR = 2'd1;
   localparam logic [1:0] ACT_MATRIX = 2'd2;

   // Register index (word address) of the dimension register
   localparam logic REG_DIMENSION = 1'b0;

   localparam logic signed [63:0] Q64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q64_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;

   typedef enum logic [1:0] {
      CMD_START,
      CMD_STORE,
      CMD_ENTRY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [3:0]         index;
      logic signed [31:0] data;
   } cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_READ,
      BK_MUL,
      BK_ACC,
      BK_RND,
      BK_SQR,
      BK_DISC,
      BK_RES,
      BK_FIN
   } back_state_type;

   typedef struct packed {
      logic idle;
      logic finishing;
   } back_stat_type;

   // a - b saturated to signed 32 bits
   function automatic logic signed [31:0] sat_sub32(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
      logic [32:0] d;
      d = {a[31], a} - {b[31], b};
      if (d[32] != d[31]) begin
         sat_sub32 = d[32] ? Q32_MIN : Q32_MAX;
      end else begin
         sat_sub32 = d[31:0];
      end
   endfunction

   // a + b saturated to signed 64 bits
   function automatic logic signed [63:0] add_sat64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
         add_sat64 = s[64] ? Q64_MIN : Q64_MAX;
      end else begin
         add_sat64 = s[63:0];
      end
   endfunction

   // Q32.32 to Q16.16, round half up, saturated
   function automatic logic signed [31:0] round_q16(input logic signed [63:0] v);
      logic [48:0] q;
      q = {v[63], v[63:16]} + {48'd0, v[15]};
      if (q[48:31] != {18{q[48]}}) begin
         round_q16 = q[48] ? Q32_MIN : Q32_MAX;
      end else begin
         round_q16 = q[31:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mvn_log_density_quadform_core.sv =====
// Timing: start and vector transactions leave no result; a matrix entry passes the back-end
//   states pop, store read, multiply and accumulate, at a row end also round, square and add,
//   and on the final entry result and finish; the density is valid the cycle after finish.
// Flow: the back end pops only when idle; start and vector commands end at the pop; matrix
//   entries keep it busy; finish waits on rsp_ready; a 2-entry queue decouples the front.
// Reset: synchronous, active high; clears control and accumulators, dimension to 1, not the store.
`default_nettype none

module mvn_log_density_quadform_core #(
   parameter int MAX_DIM = 16
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [3:0]         req_index,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_mu_value,
   input  logic signed [31:0] req_entry_value,
   input  logic signed [31:0] req_offset_value,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_log_density,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [4:0]              dimension_ff;
   logic [6:0]              dim_eff;
   logic                    csr_write;

   logic                    q_push;
   mvnq_pkg::cmd_type       q_cmd_in;
   logic                    q_pop;
   mvnq_pkg::cmd_type       q_cmd_out;
   logic                    q_full;
   logic                    q_empty;
   mvnq_pkg::back_stat_type bk_stat;

   // ---------------------------------------------------------------
   // Register port: one register (dimension) at word 0, zero wait states.
   // ---------------------------------------------------------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == mvnq_pkg::REG_DIMENSION);
   assign prdata    = (paddr[2] == mvnq_pkg::REG_DIMENSION) ? {27'd0, dimension_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         dimension_ff <= 5'd1;
      end else if (csr_write) begin
         dimension_ff <= pwdata[4:0];
      end
   end

   // Zero acts as one, anything past the store depth acts as the depth.
   always_comb begin
      if (dimension_ff == 5'd0) begin
         dim_eff = 7'd1;
      end else if (7'(dimension_ff) > 7'(MAX_DIM)) begin
         dim_eff = 7'(MAX_DIM);
      end else begin
         dim_eff = 7'(dimension_ff);
      end
   end

   // ---------------------------------------------------------------
   // Front end: classify the transaction, compute x - mu, enqueue.
   // ---------------------------------------------------------------
   mvnq_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_index        (req_index),
      .req_x_value      (req_x_value),
      .req_mu_value     (req_mu_value),
      .req_entry_value  (req_entry_value),
      .req_offset_value (req_offset_value),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_cmd_in)
   );

   // Decouples the front end from the multi-cycle back end.
   mvnq_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd_in),
      .pop      (q_pop),
      .pop_cmd  (q_cmd_out),
      .full     (q_full),
      .empty    (q_empty)
   );

   // ---------------------------------------------------------------
   // Back end: store, MAC per entry, square per row, result register.
   // The result register frees the back end to keep draining the
   // queue while a finished density waits on rsp_ready.
   // ---------------------------------------------------------------
   mvnq_back #(
      .MAX_DIM (MAX_DIM)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (q_cmd_out),
      .q_pop           (q_pop),
      .dim_eff         (dim_eff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_log_density (rsp_log_density),
      .stat            (bk_stat)
   );

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   a_result_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(bk_stat.finishing))
      else $error("result appeared without a final row");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> bk_stat.idle)
      else $error("back end took a transaction while busy");

   a_dim_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (dimension_ff == $past(pwdata[4:0])))
      else $error("dimension write lost");

   a_dim_range: assert property (@(posedge clock) disable iff (reset)
      (dim_eff >= 7'd1) && (dim_eff <= 7'(MAX_DIM)))
      else $error("effective dimension out of range");

endmodule

`default_nettype wire

// ===== rtl/mvnq_front.sv =====
// Front end: accepts input transactions, drops ignored ones, forms queue commands.
`default_nettype none

module mvnq_front #(
   parameter int MAX_DIM = 16
) (
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_action,
   input  logic [3:0]            req_index,
   input  logic signed [31:0]    req_x_value,
   input  logic signed [31:0]    req_mu_value,
   input  logic signed [31:0]    req_entry_value,
   input  logic signed [31:0]    req_offset_value,
   input  logic                  q_full,
   output logic                  q_push,
   output mvnq_pkg::cmd_type     q_cmd
);

   logic keep;

   assign req_ready = !q_full;

   always_comb begin
      keep         = 1'b0;
      q_cmd.kind   = mvnq_pkg::CMD_START;
      q_cmd.index  = req_index;
      q_cmd.data   = req_offset_value;
      case (req_action)
         mvnq_pkg::ACT_START: begin
            keep = 1'b1;
         end
         mvnq_pkg::ACT_VECTOR: begin
            // indexes past the store are dropped
            keep       = (7'(req_index) < 7'(MAX_DIM));
            q_cmd.kind = mvnq_pkg::CMD_STORE;
            q_cmd.data = mvnq_pkg::sat_sub32(req_x_value, req_mu_value);
         end
         mvnq_pkg::ACT_MATRIX: begin
            keep       = 1'b1;
            q_cmd.kind = mvnq_pkg::CMD_ENTRY;
            q_cmd.data = req_entry_value;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign q_push = req_valid && !q_full && keep;

endmodule

`default_nettype wire

// ===== rtl/mvnq_fifo.sv =====
// Two-entry command queue between front end and back end.
`default_nettype none

module mvnq_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mvnq_pkg::cmd_type push_cmd,
   input  logic              pop,
   output mvnq_pkg::cmd_type pop_cmd,
   output logic              full,
   output logic              empty
);

   mvnq_pkg::cmd_type slot_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mvnq_back.sv =====
// Back end: difference store, multiply-accumulate, row squaring and result register.
`default_nettype none

module mvnq_back #(
   parameter int MAX_DIM = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  mvnq_pkg::cmd_type       q_cmd,
   output logic                    q_pop,
   input  logic [6:0]              dim_eff,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [31:0]      rsp_log_density,
   output mvnq_pkg::back_stat_type stat
);

   localparam int PW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   mvnq_pkg::back_state_type state_ff;
   mvnq_pkg::back_state_type state_in;

   logic signed [31:0] store_mem [MAX_DIM];
   logic signed [31:0] rd_ff;
   logic signed [31:0] entry_ff;
   logic signed [63:0] prod_ff;
   logic signed [63:0] row_sum_ff;
   logic signed [63:0] disc_ff;
   logic signed [31:0] r_ff;
   logic signed [63:0] sq_ff;
   logic signed [63:0] res_ff;
   logic signed [31:0] offset_ff;
   logic signed [31:0] out_ff;
   logic               rsp_valid_ff;
   logic [PW-1:0]      row_ff;
   logic [PW-1:0]      col_ff;

   logic row_end;
   logic last_row;
   logic out_free;
   logic do_start;
   logic do_store;
   logic do_entry;
   logic out_load;

   assign row_end  = (col_ff >= row_ff);
   assign last_row = ((7'(row_ff) + 7'd1) >= dim_eff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mvnq_pkg::BK_IDLE: begin
            if (!q_empty && (q_cmd.kind == mvnq_pkg::CMD_ENTRY)) begin
               state_in = mvnq_pkg::BK_READ;
            end
         end
         mvnq_pkg::BK_READ: state_in = mvnq_pkg::BK_MUL;
         mvnq_pkg::BK_MUL:  state_in = mvnq_pkg::BK_ACC;
         mvnq_pkg::BK_ACC: begin
            state_in = row_end ? mvnq_pkg::BK_RND : mvnq_pkg::BK_IDLE;
         end
         mvnq_pkg::BK_RND:  state_in = mvnq_pkg::BK_SQR;
         mvnq_pkg::BK_SQR:  state_in = mvnq_pkg::BK_DISC;
         mvnq_pkg::BK_DISC: begin
            state_in = last_row ? mvnq_pkg::BK_RES : mvnq_pkg::BK_IDLE;
         end
         mvnq_pkg::BK_RES:  state_in = mvnq_pkg::BK_FIN;
         mvnq_pkg::BK_FIN: begin
            if (out_free) begin
               state_in = mvnq_pkg::BK_IDLE;
            end
         end
         default: state_in = mvnq_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop    = (state_ff == mvnq_pkg::BK_IDLE) && !q_empty;
      do_start = q_pop && (q_cmd.kind == mvnq_pkg::CMD_START);
      do_store = q_pop && (q_cmd.kind == mvnq_pkg::CMD_STORE);
      do_entry = q_pop && (q_cmd.kind == mvnq_pkg::CMD_ENTRY);
      out_load = (state_ff == mvnq_pkg::BK_FIN) && out_free;
   end

   // control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mvnq_pkg::BK_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         row_sum_ff   <= '0;
         disc_ff      <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (do_start || out_load) begin
            row_ff     <= '0;
            col_ff     <= '0;
            row_sum_ff <= '0;
            disc_ff    <= '0;
         end
         if (do_start) begin
            offset_ff <= q_cmd.data;
         end
         if (state_ff == mvnq_pkg::BK_ACC) begin
            row_sum_ff <= mvnq_pkg::add_sat64(row_sum_ff, prod_ff);
            if (!row_end) begin
               col_ff <= col_ff + PW'(1);
            end
         end
         if (state_ff == mvnq_pkg::BK_RND) begin
            row_sum_ff <= '0;
            col_ff     <= '0;
         end
         if (state_ff == mvnq_pkg::BK_DISC) begin
            disc_ff <= mvnq_pkg::add_sat64(disc_ff, sq_ff);
            if (!last_row) begin
               row_ff <= row_ff + PW'(1);
            end
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (do_entry) begin
         entry_ff <= q_cmd.data;
      end
      prod_ff <= 64'(entry_ff) * 64'(rd_ff);
      r_ff    <= mvnq_pkg::round_q16(row_sum_ff);
      sq_ff   <= 64'(r_ff) * 64'(r_ff);
      res_ff  <= {{16{offset_ff[31]}}, offset_ff, 16'd0} - (disc_ff >>> 1);
      if (out_load) begin
         out_ff <= mvnq_pkg::round_q16(res_ff);
      end
   end

   // difference store
   always_ff @(posedge clock) begin
      if (do_store) begin
         store_mem[PW'(q_cmd.index)] <= q_cmd.data;
      end
      if (state_ff == mvnq_pkg::BK_READ) begin
         rd_ff <= store_mem[col_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_log_density = out_ff;
   assign stat.idle       = (state_ff == mvnq_pkg::BK_IDLE);
   assign stat.finishing  = out_load;

endmodule

`default_nettype wire
